[rtl/cordic_sine_cosine_macros.svh]
// Assertion macros for the CORDIC sine/cosine block.
`ifndef CORDIC_SINE_COSINE_MACROS_SVH
`define CORDIC_SINE_COSINE_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition implies a consequence in the same cycle.
`define CSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that a condition implies a consequence a fixed number of cycles later.
`define CSC_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("assertion failed");
`else
`define CSC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CSC_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons)
`endif
`endif

[rtl/csc_pkg.sv]
// Shared types and constants for the CORDIC sine/cosine pipeline.
`default_nettype none
package csc_pkg;

    localparam int CSC_ITERATIONS = 14;
    localparam int CSC_WORD_W     = 18;
    localparam int CSC_ANGLE_W    = 16;
    localparam int CSC_OUT_W      = 16;
    // pipeline depth: fold stage, one stage per rotation, output stage
    localparam int CSC_LATENCY    = CSC_ITERATIONS + 2;

    typedef logic signed [CSC_WORD_W-1:0] t_csc_word;

    localparam t_csc_word CSC_X_START   = 18'sd9949;
    localparam t_csc_word CSC_HALF_TURN = 18'sd32768;
    localparam t_csc_word CSC_FULL_TURN = 18'sd65536;

    // Rounded atan(2^-i) in quarter-turn units of 16384.
    localparam t_csc_word CSC_ATAN_ROM [0:CSC_ITERATIONS-1] = '{
        18'sd8192, 18'sd4836, 18'sd2555, 18'sd1297, 18'sd651, 18'sd326, 18'sd163,
        18'sd81, 18'sd41, 18'sd20, 18'sd10, 18'sd5, 18'sd3, 18'sd1
    };

    // Quadrant codes taken from the top two angle bits.
    typedef enum logic [1:0] {
        QUAD_FIRST  = 2'd0,
        QUAD_SECOND = 2'd1,
        QUAD_THIRD  = 2'd2,
        QUAD_FOURTH = 2'd3
    } t_csc_quad;

    // Control that travels alongside each request in the pipeline.
    typedef struct packed {
        logic valid;
        logic neg_cos;
        logic neg_sin;
    } t_csc_ctl;

endpackage
`default_nettype wire

[rtl/cordic_sine_cosine.sv]
// Top level of the pipelined CORDIC sine/cosine generator.
//
//   Channel  Direction  Handshake           Payload
//   request  in         start, busy         i_angle (16b unsigned, 65536 per turn)
//   result   out        o_done strobe       o_sine_value, o_cosine_value (16b signed)
//
// One request may be taken every cycle; busy is always low.
// Each result passes through one quadrant fold stage,
// fourteen rotation stages (one shift-add each) and one sign/output stage.
// Synchronous active-low reset clears the valid bits and drops requests in flight.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
`include "cordic_sine_cosine_macros.svh"
module cordic_sine_cosine (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [csc_pkg::CSC_ANGLE_W-1:0]     i_angle,
    output logic                                     o_done,
    output logic signed [csc_pkg::CSC_OUT_W-1:0]     o_sine_value,
    output logic signed [csc_pkg::CSC_OUT_W-1:0]     o_cosine_value
);
    import csc_pkg::*;

    t_csc_quad quad;
    t_csc_word z_fold;
    t_csc_ctl  n_ctl;
    t_csc_ctl  r_ctl;
    t_csc_word r_z;
    t_csc_ctl  rot_ctl;
    t_csc_word rot_x;
    t_csc_word rot_y;
    t_csc_word n_sin;
    t_csc_word n_cos;
    logic      r_done;
    logic signed [CSC_OUT_W-1:0] r_sine;
    logic signed [CSC_OUT_W-1:0] r_cosine;
    logic      sin_in_range;
    logic      cos_in_range;

    assign busy = 1'b0;

    // fold the angle into the first quadrant
    assign quad = t_csc_quad'(i_angle[CSC_ANGLE_W-1 -: 2]);

    always_comb begin
        unique case (quad)
            QUAD_FIRST:  z_fold = t_csc_word'({2'b00, i_angle});
            QUAD_SECOND: z_fold = CSC_HALF_TURN - t_csc_word'({2'b00, i_angle});
            QUAD_THIRD:  z_fold = t_csc_word'({2'b00, i_angle}) - CSC_HALF_TURN;
            QUAD_FOURTH: z_fold = CSC_FULL_TURN - t_csc_word'({2'b00, i_angle});
            default:     z_fold = '0;
        endcase
        n_ctl.valid   = start && !busy;
        n_ctl.neg_cos = (quad == QUAD_SECOND) || (quad == QUAD_THIRD);
        n_ctl.neg_sin = (quad == QUAD_THIRD) || (quad == QUAD_FOURTH);
    end

    // fold stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    // hold the negated residual angle
    always_ff @(posedge i_clk) begin
        r_z <= -z_fold;
    end

    csc_rotator u_rotator (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl),
        .i_x     (CSC_X_START),
        .i_y     ('0),
        .i_z     (r_z),
        .o_ctl   (rot_ctl),
        .o_x     (rot_x),
        .o_y     (rot_y)
    );

    // apply the quadrant signs
    assign n_sin = rot_ctl.neg_sin ? -rot_y : rot_y;
    assign n_cos = rot_ctl.neg_cos ? -rot_x : rot_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= rot_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sine   <= n_sin[CSC_OUT_W-1:0];
        r_cosine <= n_cos[CSC_OUT_W-1:0];
    end

    assign o_done         = r_done;
    assign o_sine_value   = r_sine;
    assign o_cosine_value = r_cosine;

    // magnitude bounds for the range checks
    assign sin_in_range = (o_sine_value <= 16'sd16600) && (o_sine_value >= -16'sd16600);
    assign cos_in_range = (o_cosine_value <= 16'sd16600) && (o_cosine_value >= -16'sd16600);

    // every request yields its strobe after the fixed latency
    `CSC_ASSERT_DELAY(a_latency, i_clk, i_rst_n, start && !busy, CSC_LATENCY, o_done)
    // no strobe without a request that far back
    `CSC_ASSERT_SAME(a_no_spurious, i_clk, i_rst_n, o_done, $past(start && !busy, CSC_LATENCY))
    // results stay near unit magnitude
    `CSC_ASSERT_SAME(a_sin_range, i_clk, i_rst_n, o_done, sin_in_range)
    `CSC_ASSERT_SAME(a_cos_range, i_clk, i_rst_n, o_done, cos_in_range)

endmodule
`default_nettype wire

[rtl/csc_rotator.sv]
// Fourteen-stage CORDIC rotation pipeline, one shift-add rotation per stage.
`default_nettype none
module csc_rotator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire csc_pkg::t_csc_ctl  i_ctl,
    input  wire csc_pkg::t_csc_word i_x,
    input  wire csc_pkg::t_csc_word i_y,
    input  wire csc_pkg::t_csc_word i_z,
    output csc_pkg::t_csc_ctl       o_ctl,
    output csc_pkg::t_csc_word      o_x,
    output csc_pkg::t_csc_word      o_y
);
    import csc_pkg::*;

    t_csc_ctl  w_ctl [0:CSC_ITERATIONS];
    t_csc_word w_x   [0:CSC_ITERATIONS];
    t_csc_word w_y   [0:CSC_ITERATIONS];
    t_csc_word w_z   [0:CSC_ITERATIONS-1];

    assign w_ctl[0] = i_ctl;
    assign w_x[0]   = i_x;
    assign w_y[0]   = i_y;
    assign w_z[0]   = i_z;

    for (genvar k = 0; k < CSC_ITERATIONS; k++) begin : g_stage
        t_csc_ctl  r_ctl;
        t_csc_word r_x;
        t_csc_word r_y;
        t_csc_word n_x;
        t_csc_word n_y;
        t_csc_word x_sh;
        t_csc_word y_sh;

        // shifted coordinates, arithmetic so negatives round down
        assign x_sh = w_x[k] >>> k;
        assign y_sh = w_y[k] >>> k;

        // rotate toward zero residual: direction set by the residual sign
        always_comb begin
            if (w_z[k][CSC_WORD_W-1]) begin
                n_y = w_y[k] + x_sh;
                n_x = w_x[k] - y_sh;
            end else begin
                n_y = w_y[k] - x_sh;
                n_x = w_x[k] + y_sh;
            end
        end

        // advance the valid bit; reset drops requests in flight
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else begin
                r_ctl <= w_ctl[k];
            end
        end

        // hold the vector of this stage
        always_ff @(posedge i_clk) begin
            r_x <= n_x;
            r_y <= n_y;
        end

        assign w_ctl[k+1] = r_ctl;
        assign w_x[k+1]   = r_x;
        assign w_y[k+1]   = r_y;

        // the next residual angle is needed by every stage but the last
        if (k < CSC_ITERATIONS - 1) begin : g_resid
            t_csc_word r_z;
            t_csc_word n_z;

            always_comb begin
                if (w_z[k][CSC_WORD_W-1]) begin
                    n_z = w_z[k] + CSC_ATAN_ROM[k];
                end else begin
                    n_z = w_z[k] - CSC_ATAN_ROM[k];
                end
            end

            always_ff @(posedge i_clk) begin
                r_z <= n_z;
            end

            assign w_z[k+1] = r_z;
        end
    end

    assign o_ctl = w_ctl[CSC_ITERATIONS];
    assign o_x   = w_x[CSC_ITERATIONS];
    assign o_y   = w_y[CSC_ITERATIONS];

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the pipelined CORDIC sine/cosine generator.
module tb_top;
    import csc_pkg::*;

    localparam int ROTATIONS      = 14;
    localparam int SEED_X         = 9949;
    localparam int HALF_CIRCLE    = 32768;
    localparam int FULL_CIRCLE    = 65536;
    localparam int QUARTER_CIRCLE = 16384;
    localparam int ANGLE_COUNT    = 1650;
    localparam int CYCLE_LIMIT    = 100000;

    // Rounded atan(2^-i) in units of 16384 per quarter turn.
    localparam int ATAN_STEP [ROTATIONS] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1
    };

    typedef struct packed {
        logic [CSC_ANGLE_W-1:0]      angle;
        logic signed [CSC_OUT_W-1:0] sine;
        logic signed [CSC_OUT_W-1:0] cosine;
    } t_trig_expect;

    // Holds the predicted sine/cosine of each accepted angle, oldest first.
    class trig_scoreboard;
        t_trig_expect pending_trig[$];
        int           mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // Fold into the first quadrant, rotate, then restore the quadrant signs.
        function void predict_sin_cos(input logic [CSC_ANGLE_W-1:0] angle,
                                      output logic signed [CSC_OUT_W-1:0] sine,
                                      output logic signed [CSC_OUT_W-1:0] cosine);
            int        resid;
            int        x;
            int        y;
            int        nx;
            int        ny;
            t_csc_quad quad;
            quad = t_csc_quad'(angle[CSC_ANGLE_W-1 -: 2]);
            case (quad)
                QUAD_FIRST:  resid = int'(angle);
                QUAD_SECOND: resid = HALF_CIRCLE - int'(angle);
                QUAD_THIRD:  resid = int'(angle) - HALF_CIRCLE;
                default:     resid = FULL_CIRCLE - int'(angle);
            endcase
            x     = SEED_X;
            y     = 0;
            resid = -resid;
            for (int i = 0; i < ROTATIONS; i++) begin
                if (resid < 0) begin
                    resid += ATAN_STEP[i];
                    ny = y + (x >>> i);
                    nx = x - (y >>> i);
                end else begin
                    resid -= ATAN_STEP[i];
                    ny = y - (x >>> i);
                    nx = x + (y >>> i);
                end
                x = nx;
                y = ny;
            end
            if (quad == QUAD_SECOND || quad == QUAD_THIRD) x = -x;
            if (quad == QUAD_THIRD || quad == QUAD_FOURTH) y = -y;
            sine   = y[CSC_OUT_W-1:0];
            cosine = x[CSC_OUT_W-1:0];
        endfunction

        function void note_request(input logic [CSC_ANGLE_W-1:0] angle);
            t_trig_expect item;
            item.angle = angle;
            predict_sin_cos(angle, item.sine, item.cosine);
            pending_trig.push_back(item);
        endfunction

        function void flag(input string what, input logic [CSC_ANGLE_W-1:0] angle,
                           input logic signed [CSC_OUT_W-1:0] want,
                           input logic signed [CSC_OUT_W-1:0] got);
            mismatch_count++;
            $display("%0t: %s of angle %0d: expected %0d, actual %0d",
                     $time, what, angle, want, got);
        endfunction

        function void check_result(input logic signed [CSC_OUT_W-1:0] sine,
                                   input logic signed [CSC_OUT_W-1:0] cosine);
            t_trig_expect item;
            if (pending_trig.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, actual sine %0d cosine %0d",
                         $time, sine, cosine);
                return;
            end
            item = pending_trig.pop_front();
            if (sine !== item.sine) flag("sine", item.angle, item.sine, sine);
            if (cosine !== item.cosine) flag("cosine", item.angle, item.cosine, cosine);
        endfunction

        function int pending();
            return pending_trig.size();
        endfunction
    endclass

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start   = 1'b0;
    logic [CSC_ANGLE_W-1:0]      i_angle = '0;
    logic                        busy;
    logic                        o_done;
    logic signed [CSC_OUT_W-1:0] o_sine_value;
    logic signed [CSC_OUT_W-1:0] o_cosine_value;

    trig_scoreboard trig_sb = new();
    int             cycle_count = 0;

    cordic_sine_cosine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_angle        (i_angle),
        .o_done         (o_done),
        .o_sine_value   (o_sine_value),
        .o_cosine_value (o_cosine_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Note accepted requests and check each strobed result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && busy === 1'b0) trig_sb.note_request(i_angle);
            if (o_done === 1'b1) trig_sb.check_result(o_sine_value, o_cosine_value);
        end
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Present one angle and hold it until the block takes it.
    task automatic send_angle(input logic [CSC_ANGLE_W-1:0] angle);
        start   <= 1'b1;
        i_angle <= angle;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Drop start and put noise on the angle bus while idle.
    task automatic idle_cycles(input int n);
        repeat (n) begin
            start   <= 1'b0;
            i_angle <= CSC_ANGLE_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    function automatic logic [CSC_ANGLE_W-1:0] pick_angle();
        int base;
        // mostly uniform, sometimes right around a quadrant boundary
        if ($urandom_range(0, 7) == 0) begin
            base = QUARTER_CIRCLE * int'($urandom_range(0, 3));
            return CSC_ANGLE_W'(base + int'($urandom_range(0, 6)) - 3);
        end
        return CSC_ANGLE_W'($urandom_range(0, FULL_CIRCLE - 1));
    endfunction

    initial begin
        logic [CSC_ANGLE_W-1:0] directed [$];
        bit                     quiet;
        directed = '{16'd0, 16'd1, 16'd8192, 16'd16383, 16'd16384, 16'd16385,
                     16'd24576, 16'd32767, 16'd32768, 16'd32769, 16'd40960,
                     16'd49151, 16'd49152, 16'd49153, 16'd57344, 16'd65534,
                     16'd65535, 16'h5555, 16'hAAAA, 16'd11585};

        // hold reset, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, every quadrant and each quadrant boundary, back to back
        foreach (directed[k]) send_angle(directed[k]);
        idle_cycles(3);

        // random angles with random gaps, one long stretch without gaps
        for (int n = 0; n < ANGLE_COUNT; n++) begin
            quiet = (n >= 600 && n < 900);
            if (!quiet && $urandom_range(0, 99) < 8) idle_cycles($urandom_range(1, 4));
            send_angle(pick_angle());
        end
        start <= 1'b0;

        // drain the pipeline, then idle past the pipeline latency for a margin
        while (trig_sb.pending() != 0) @(posedge i_clk);
        repeat (CSC_LATENCY + 4) @(posedge i_clk);

        if (trig_sb.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
